// ===== hw/rtl/i2c_light_led_slave_controller_defines.svh =====
// -----------------------------------------------------------------------------
// Light sensor and LED node: shared assertion macros.
// These checks are clocked on clk and are off while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef I2C_LIGHT_LED_SLAVE_CONTROLLER_DEFINES_SVH
`define I2C_LIGHT_LED_SLAVE_CONTROLLER_DEFINES_SVH

// The condition must hold at every clock edge.
`define ILLSC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequence must hold in the same cycle as the antecedent.
`define ILLSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define ILLSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/illsc_pkg.sv =====
// -----------------------------------------------------------------------------
// Light sensor and LED node package
// Types, codes and constants shared by the modules of the node.
// -----------------------------------------------------------------------------
package illsc_pkg;

    localparam int AVG_SAMPLES = 40;
    localparam int SUM_W       = 18;
    localparam int AVG_W       = 12;
    localparam int COUNT_W     = $clog2(AVG_SAMPLES + 1);
    localparam int AVG_SHIFT   = 24;
    localparam int RECIP_W     = AVG_SHIFT + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((2 ** AVG_SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES);
    localparam logic [COUNT_W-1:0] AVG_COUNT = COUNT_W'(AVG_SAMPLES);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BOOT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAKE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FW_VERSION   = 2'd3;

    localparam logic [15:0] BOOT_TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] WAKE_TIMEOUT_RESET = 16'd500;
    localparam logic [7:0]  LED_COUNT_RESET    = 8'd14;
    localparam logic [7:0]  FW_VERSION_RESET   = 8'd1;

    localparam logic [1:0] ACT_SAMPLE  = 2'd0;
    localparam logic [1:0] ACT_COMMAND = 2'd1;
    localparam logic [1:0] ACT_ADDRESS = 2'd2;
    localparam logic [1:0] ACT_TICK    = 2'd3;

    localparam logic [7:0] CMD_LIGHT   = 8'h00;
    localparam logic [7:0] CMD_LED     = 8'h01;
    localparam logic [7:0] CMD_STANDBY = 8'h02;
    localparam logic [7:0] CMD_VERSION = 8'hFE;

    localparam logic [7:0] MSG_LEN_FULL = 8'd5;

    localparam logic [1:0] RES_LED   = 2'd0;
    localparam logic [1:0] RES_REPLY = 2'd1;
    localparam logic [1:0] RES_STOP  = 2'd2;

    localparam logic [1:0] REPLY_LEN_NONE    = 2'd0;
    localparam logic [1:0] REPLY_LEN_VERSION = 2'd1;
    localparam logic [1:0] REPLY_LEN_LIGHT   = 2'd2;

    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] adc_sample;
        logic [7:0]  cmd_byte;
        logic [7:0]  led_index;
        logic [7:0]  green_byte;
        logic [7:0]  red_byte;
        logic [7:0]  blue_byte;
        logic [7:0]  msg_len;
        logic        bus_busy;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        led_all;
        logic [7:0]  led_target;
        logic [23:0] led_colour;
        logic [15:0] reply_data;
        logic [1:0]  reply_len;
    } result_t;

    typedef struct packed {
        logic [15:0] boot_timeout_ms;
        logic [15:0] wake_timeout_ms;
        logic [7:0]  led_count;
        logic [7:0]  firmware_version;
    } cfg_t;

endpackage

// ===== hw/rtl/illsc_cfg.sv =====
// -----------------------------------------------------------------------------
// Configuration registers
// Holds the timeouts, the LED count and the version byte.
// -----------------------------------------------------------------------------
module illsc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [illsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [illsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output illsc_pkg::cfg_t                    cfg
);
    import illsc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boot_timeout_ms  <= BOOT_TIMEOUT_RESET;
            cfg_reg.wake_timeout_ms  <= WAKE_TIMEOUT_RESET;
            cfg_reg.led_count        <= LED_COUNT_RESET;
            cfg_reg.firmware_version <= FW_VERSION_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BOOT_TIMEOUT: cfg_reg.boot_timeout_ms  <= cfg_data;
                REG_WAKE_TIMEOUT: cfg_reg.wake_timeout_ms  <= cfg_data;
                REG_LED_COUNT:    cfg_reg.led_count        <= cfg_data[7:0];
                REG_FW_VERSION:   cfg_reg.firmware_version <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/illsc_avg.sv =====
// -----------------------------------------------------------------------------
// Light sample averager
// Sums blocks of ADC samples and stores the truncated mean of each block.
// -----------------------------------------------------------------------------
`include "i2c_light_led_slave_controller_defines.svh"

module illsc_avg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_en,
    input  logic [11:0]                   adc_sample,
    output logic [illsc_pkg::AVG_W-1:0]   light_average
);
    import illsc_pkg::*;

    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic [AVG_W-1:0]           avg_reg;
    logic [SUM_W+RECIP_W-1:0]   product;
    logic                       block_done;

    assign sum_next   = sum_reg + SUM_W'(adc_sample);
    assign count_next = count_reg + COUNT_W'(1);
    assign block_done = (count_next >= AVG_COUNT);
    assign product    = (SUM_W + RECIP_W)'(sum_next) * (SUM_W + RECIP_W)'(AVG_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            avg_reg   <= '0;
        end
        else if (sample_en)
        begin
            if (block_done)
            begin
                avg_reg   <= product[AVG_SHIFT +: AVG_W];
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
        end
    end

    assign light_average = avg_reg;

    `ILLSC_ASSERT_ALWAYS(a_count_below_block, count_reg < AVG_COUNT, "sample count overran block")
    `ILLSC_ASSERT_NEXT(a_block_restart, sample_en && block_done, sum_reg == '0 && count_reg == '0, "block did not restart")

endmodule

// ===== hw/rtl/illsc_ctrl.sv =====
// -----------------------------------------------------------------------------
// Command decoder and power control
// Decodes bus messages, counts idle time and requests stop mode.
// -----------------------------------------------------------------------------
`include "i2c_light_led_slave_controller_defines.svh"

module illsc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  illsc_pkg::item_t              item,
    input  illsc_pkg::cfg_t               cfg,
    input  logic [illsc_pkg::AVG_W-1:0]   light_average,
    output logic                          res_valid,
    output illsc_pkg::result_t            res
);
    import illsc_pkg::*;

    logic [15:0]  idle_reg;
    logic         woke_reg;
    logic         sleep_reg;
    logic [15:0]  idle_next;
    logic         sleep_next;
    logic         decoded;
    logic         produced;
    logic         stop;
    logic [15:0]  limit;
    result_t      cmd_res;

    always_comb
    begin
        idle_next = idle_reg;
        case (item.action)
            ACT_SAMPLE:  idle_next = idle_reg;
            ACT_COMMAND: idle_next = '0;
            ACT_ADDRESS: idle_next = '0;
            ACT_TICK:    idle_next = (idle_reg < IDLE_MAX) ? idle_reg + 16'd1 : idle_reg;
            default:     idle_next = idle_reg;
        endcase
    end

    assign decoded = (item.action == ACT_COMMAND) && (item.msg_len != '0);

    always_comb
    begin
        cmd_res    = '0;
        produced   = 1'b0;
        sleep_next = sleep_reg;
        if (decoded)
        begin
            case (item.cmd_byte)
                CMD_LED:
                begin
                    produced               = 1'b1;
                    cmd_res.result_kind    = RES_LED;
                    cmd_res.led_colour     = {item.red_byte, item.green_byte, item.blue_byte};
                    if ((item.led_index >= cfg.led_count) && (item.msg_len == MSG_LEN_FULL))
                    begin
                        cmd_res.led_all = 1'b1;
                    end
                    else
                    begin
                        cmd_res.led_target = item.led_index;
                    end
                end
                CMD_LIGHT:
                begin
                    produced            = 1'b1;
                    cmd_res.result_kind = RES_REPLY;
                    cmd_res.reply_data  = 16'(light_average);
                    cmd_res.reply_len   = REPLY_LEN_LIGHT;
                end
                CMD_VERSION:
                begin
                    produced            = 1'b1;
                    cmd_res.result_kind = RES_REPLY;
                    cmd_res.reply_data  = 16'(cfg.firmware_version);
                    cmd_res.reply_len   = REPLY_LEN_VERSION;
                end
                CMD_STANDBY:
                begin
                    sleep_next = 1'b1;
                end
                default:
                begin
                    produced = 1'b0;
                end
            endcase
        end
    end

    assign limit = woke_reg ? cfg.wake_timeout_ms : cfg.boot_timeout_ms;
    assign stop  = !produced && (sleep_next || (idle_next >= limit)) && !item.bus_busy;

    always_comb
    begin
        res = cmd_res;
        if (stop)
        begin
            res             = '0;
            res.result_kind = RES_STOP;
        end
    end

    assign res_valid = produced || stop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg  <= '0;
            woke_reg  <= 1'b0;
            sleep_reg <= 1'b0;
        end
        else if (step)
        begin
            idle_reg  <= stop ? '0 : idle_next;
            sleep_reg <= stop ? 1'b0 : sleep_next;
            woke_reg  <= woke_reg || stop;
        end
    end

    `ILLSC_ASSERT_NEXT(a_stop_clears_state, step && stop, idle_reg == '0 && !sleep_reg && woke_reg, "stop left idle state behind")
    `ILLSC_ASSERT_SAME(a_stop_needs_free_bus, stop, !item.bus_busy && !produced, "stop requested while bus busy")

endmodule

// ===== hw/rtl/i2c_light_led_slave_controller.sv =====
// -----------------------------------------------------------------------------
// Light sensor and LED node controller: top level
// An accepted item is held in the input register, then any result it gives is registered; a result stall holds both.
// Throughput: one item per cycle while result_stall is low, set by the input and result registers.
// Reset clears all control state and loads the register defaults at once.
// -----------------------------------------------------------------------------
`include "i2c_light_led_slave_controller_defines.svh"

module i2c_light_led_slave_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [illsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [illsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  illsc_pkg::item_t                   item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output illsc_pkg::result_t                 result
);
    import illsc_pkg::*;

    cfg_t              cfg;
    logic              stage_valid_reg;
    item_t             stage_item_reg;
    logic              result_valid_reg;
    result_t           result_reg;
    logic              advance;
    logic              accept;
    logic              res_valid;
    result_t           res;
    logic [AVG_W-1:0]  light_average;

    assign advance    = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = stage_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    illsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    illsc_avg u_avg (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_en     (advance && (stage_item_reg.action == ACT_SAMPLE)),
        .adc_sample    (stage_item_reg.adc_sample),
        .light_average (light_average)
    );

    illsc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .item          (stage_item_reg),
        .cfg           (cfg),
        .light_average (light_average),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && res_valid)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ILLSC_ASSERT_SAME(a_stall_only_when_full, item_stall, stage_valid_reg && result_valid_reg && result_stall, "input stalled without cause")
    `ILLSC_ASSERT_SAME(a_stop_is_bare, result_valid && (result.result_kind == RES_STOP), result.led_colour == '0 && result.reply_len == REPLY_LEN_NONE && !result.led_all, "stop result carries payload")
    `ILLSC_ASSERT_SAME(a_led_no_reply, result_valid && (result.result_kind == RES_LED), result.reply_len == REPLY_LEN_NONE && result.reply_data == '0, "LED update carries reply")

endmodule
